@@ rtl/core/lsx_block_cipher_round_assert.svh @@
// ----------------------------------------------------------------------------
// lsx block cipher round assertion macros
// Concurrent assertion helpers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef LSX_BLOCK_CIPHER_ROUND_ASSERT_SVH
`define LSX_BLOCK_CIPHER_ROUND_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle
`define LSX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsx assertion failed");

// property that must hold in the next cycle
`define LSX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsx assertion failed");

`else

`define LSX_ASSERT_NOW(lbl, ante, cons)
`define LSX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/lsx_pkg.sv @@
// ----------------------------------------------------------------------------
// lsx package
// Pi substitution table, R step weights and GF(2^8) helpers for the round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsx_pkg;

	typedef logic [7:0]   byte_t;
	typedef logic [127:0] block_t;
	typedef logic [63:0]  half_t;

	localparam int LSX_BYTES       = 16;
	localparam int LSX_R_STEPS     = 16;
	localparam int LSX_R_PER_STAGE = 4;

	// low byte of the field polynomial x^8+x^7+x^6+x+1
	localparam byte_t LSX_POLY_LOW = 8'hC3;

	// published Pi substitution table
	localparam byte_t LSX_PI [256] = '{
		8'd252, 8'd238, 8'd221, 8'd17,  8'd207, 8'd110, 8'd49,  8'd22,
		8'd251, 8'd196, 8'd250, 8'd218, 8'd35,  8'd197, 8'd4,   8'd77,
		8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46,  8'd153, 8'd186,
		8'd23,  8'd54,  8'd241, 8'd187, 8'd20,  8'd205, 8'd95,  8'd193,
		8'd249, 8'd24,  8'd101, 8'd90,  8'd226, 8'd92,  8'd239, 8'd33,
		8'd129, 8'd28,  8'd60,  8'd66,  8'd139, 8'd1,   8'd142, 8'd79,
		8'd5,   8'd132, 8'd2,   8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
		8'd6,   8'd11,  8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
		8'd235, 8'd52,  8'd44,  8'd81,  8'd234, 8'd200, 8'd72,  8'd171,
		8'd242, 8'd42,  8'd104, 8'd162, 8'd253, 8'd58,  8'd206, 8'd204,
		8'd181, 8'd112, 8'd14,  8'd86,  8'd8,   8'd12,  8'd118, 8'd18,
		8'd191, 8'd114, 8'd19,  8'd71,  8'd156, 8'd183, 8'd93,  8'd135,
		8'd21,  8'd161, 8'd150, 8'd41,  8'd16,  8'd123, 8'd154, 8'd199,
		8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
		8'd50,  8'd117, 8'd25,  8'd61,  8'd255, 8'd53,  8'd138, 8'd126,
		8'd109, 8'd84,  8'd198, 8'd128, 8'd195, 8'd189, 8'd13,  8'd87,
		8'd223, 8'd245, 8'd36,  8'd169, 8'd62,  8'd168, 8'd67,  8'd201,
		8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34,  8'd185, 8'd3,
		8'd224, 8'd15,  8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
		8'd220, 8'd232, 8'd40,  8'd80,  8'd78,  8'd51,  8'd10,  8'd74,
		8'd167, 8'd151, 8'd96,  8'd115, 8'd30,  8'd0,   8'd98,  8'd68,
		8'd26,  8'd184, 8'd56,  8'd130, 8'd100, 8'd159, 8'd38,  8'd65,
		8'd173, 8'd69,  8'd70,  8'd146, 8'd39,  8'd94,  8'd85,  8'd47,
		8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
		8'd7,   8'd88,  8'd179, 8'd64,  8'd134, 8'd172, 8'd29,  8'd247,
		8'd48,  8'd55,  8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
		8'd225, 8'd27,  8'd131, 8'd73,  8'd76,  8'd63,  8'd248, 8'd254,
		8'd141, 8'd83,  8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
		8'd32,  8'd113, 8'd103, 8'd164, 8'd45,  8'd43,  8'd9,   8'd91,
		8'd203, 8'd155, 8'd37,  8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
		8'd89,  8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
		8'd209, 8'd102, 8'd175, 8'd194, 8'd57,  8'd75,  8'd99,  8'd182
	};

	// weight of byte i in the R step sum
	localparam byte_t LSX_WEIGHT [LSX_BYTES] = '{
		8'd1,   8'd148, 8'd32,  8'd133, 8'd16,  8'd194, 8'd192, 8'd1,
		8'd251, 8'd1,   8'd192, 8'd194, 8'd16,  8'd133, 8'd32,  8'd148
	};

	// multiply by x in GF(2^8)
	function automatic byte_t lsx_xtime(input byte_t a);
		lsx_xtime = {a[6:0], 1'b0} ^ (a[7] ? LSX_POLY_LOW : 8'h00);
	endfunction

	// multiply by a constant weight; reduces to an xor network
	function automatic byte_t lsx_gf_mul(input byte_t a, input byte_t c);
		byte_t acc;
		byte_t x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (c[i]) begin
				acc = acc ^ x;
			end
			x = lsx_xtime(x);
		end
		lsx_gf_mul = acc;
	endfunction

	// one R step: weighted byte sum enters at the top, bytes move down
	function automatic block_t lsx_r_step(input block_t b);
		byte_t sum;
		sum = 8'h00;
		for (int i = 0; i < LSX_BYTES; i++) begin
			sum = sum ^ lsx_gf_mul(b[8*i +: 8], LSX_WEIGHT[i]);
		end
		lsx_r_step = {sum, b[127:8]};
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lsx_sub_bytes.sv @@
// ----------------------------------------------------------------------------
// lsx sub bytes
// Key addition followed by the Pi substitution on all sixteen bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsx_sub_bytes (
	input  wire lsx_pkg::block_t key,
	input  wire lsx_pkg::block_t blk_in,
	output lsx_pkg::block_t      blk_out
);
	import lsx_pkg::*;

	block_t mixed;

	// key addition
	assign mixed = blk_in ^ key;

	// byte substitution
	always_comb begin
		for (int i = 0; i < LSX_BYTES; i++) begin
			blk_out[8*i +: 8] = LSX_PI[mixed[8*i +: 8]];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lsx_lin_part.sv @@
// ----------------------------------------------------------------------------
// lsx linear part
// A slice of the linear transform: a fixed number of chained R steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsx_lin_part (
	input  wire lsx_pkg::block_t blk_in,
	output lsx_pkg::block_t      blk_out
);
	import lsx_pkg::*;

	// chained R steps for this slice
	always_comb begin
		block_t b;
		b = blk_in;
		for (int k = 0; k < LSX_R_PER_STAGE; k++) begin
			b = lsx_r_step(b);
		end
		blk_out = b;
	end

endmodule

`default_nettype wire

@@ rtl/core/lsx_block_cipher_round.sv @@
// ----------------------------------------------------------------------------
// lsx block cipher round
// One forward LSX round: key addition, Pi substitution, linear transform L.
// ----------------------------------------------------------------------------
// The round accepts one 128-bit block with its round key in every clock cycle
// while blk_ready is high and returns L(S(key ^ data)) through its register
// stages: the first register stage holds the substituted block, and each of
// the next four stages applies four of the sixteen R steps of L, the last of
// them being the output register. Each stage holds one transaction; a stall on
// the result side backs up stage by stage, so the block keeps taking
// transactions until every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module lsx_block_cipher_round (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 blk_valid,
	output logic                blk_ready,
	input  wire lsx_pkg::half_t key_hi,
	input  wire lsx_pkg::half_t key_lo,
	input  wire lsx_pkg::half_t data_hi,
	input  wire lsx_pkg::half_t data_lo,
	output logic                res_valid,
	input  wire                 res_ready,
	output lsx_pkg::half_t      out_hi,
	output lsx_pkg::half_t      out_lo
);
	import lsx_pkg::*;

	`include "lsx_block_cipher_round_assert.svh"

	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic   rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	block_t blk_s1, blk_s2, blk_s3, blk_s4, blk_s5;
	block_t sub_out, lin_out1, lin_out2, lin_out3, lin_out4;
	logic [4:0] v_all;

	// stage can load when empty or when its content moves on
	assign rdy_s5 = !v_s5 || res_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign blk_ready = rdy_s1;
	assign res_valid = v_s5;
	assign out_hi    = blk_s5[127:64];
	assign out_lo    = blk_s5[63:0];
	assign v_all     = {v_s5, v_s4, v_s3, v_s2, v_s1};

	// datapath slices
	lsx_sub_bytes u_sub (
		.key     ({key_hi, key_lo}),
		.blk_in  ({data_hi, data_lo}),
		.blk_out (sub_out)
	);

	lsx_lin_part u_lin1 (.blk_in(blk_s1), .blk_out(lin_out1));
	lsx_lin_part u_lin2 (.blk_in(blk_s2), .blk_out(lin_out2));
	lsx_lin_part u_lin3 (.blk_in(blk_s3), .blk_out(lin_out3));
	lsx_lin_part u_lin4 (.blk_in(blk_s4), .blk_out(lin_out4));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= blk_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// block registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && blk_valid) blk_s1 <= sub_out;
		if (rdy_s2 && v_s1)      blk_s2 <= lin_out1;
		if (rdy_s3 && v_s2)      blk_s3 <= lin_out2;
		if (rdy_s4 && v_s3)      blk_s4 <= lin_out3;
		if (rdy_s5 && v_s4)      blk_s5 <= lin_out4;
	end

	// input backpressure only comes from a stalled result
	`LSX_ASSERT_NOW(a_ready_low_stall, !blk_ready, res_valid && !res_ready)
	// a stalled result never drops a transaction in flight
	`LSX_ASSERT_NEXT(a_no_drop, res_valid && !res_ready, $countones(v_all) >= $past($countones(v_all)))
	// an empty pipeline cannot produce a result in the next cycle
	`LSX_ASSERT_NEXT(a_no_invent, v_all == 5'b00000, !res_valid)

endmodule

`default_nettype wire

@@ tb/sv/lsx_block_cipher_round_tb.sv @@
// ----------------------------------------------------------------------------
// lsx block cipher round testbench
// Drives key and data blocks through the round under random idling and long
// result-side stalls, predicts L(S(key ^ data)) with an independent bytewise
// model and checks every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsx_block_cipher_round_tb;

	import lsx_pkg::half_t;
	import lsx_pkg::block_t;

	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          LONG_HOLD      = 120;
	localparam int          TAIL_CYCLES    = 20;
	localparam logic [7:0]  GF_REDUCE      = 8'hC3;

	// byte substitution table of the round
	localparam logic [7:0] PI_SBOX [256] = '{
		8'd252, 8'd238, 8'd221, 8'd17,  8'd207, 8'd110, 8'd49,  8'd22,
		8'd251, 8'd196, 8'd250, 8'd218, 8'd35,  8'd197, 8'd4,   8'd77,
		8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46,  8'd153, 8'd186,
		8'd23,  8'd54,  8'd241, 8'd187, 8'd20,  8'd205, 8'd95,  8'd193,
		8'd249, 8'd24,  8'd101, 8'd90,  8'd226, 8'd92,  8'd239, 8'd33,
		8'd129, 8'd28,  8'd60,  8'd66,  8'd139, 8'd1,   8'd142, 8'd79,
		8'd5,   8'd132, 8'd2,   8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
		8'd6,   8'd11,  8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
		8'd235, 8'd52,  8'd44,  8'd81,  8'd234, 8'd200, 8'd72,  8'd171,
		8'd242, 8'd42,  8'd104, 8'd162, 8'd253, 8'd58,  8'd206, 8'd204,
		8'd181, 8'd112, 8'd14,  8'd86,  8'd8,   8'd12,  8'd118, 8'd18,
		8'd191, 8'd114, 8'd19,  8'd71,  8'd156, 8'd183, 8'd93,  8'd135,
		8'd21,  8'd161, 8'd150, 8'd41,  8'd16,  8'd123, 8'd154, 8'd199,
		8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
		8'd50,  8'd117, 8'd25,  8'd61,  8'd255, 8'd53,  8'd138, 8'd126,
		8'd109, 8'd84,  8'd198, 8'd128, 8'd195, 8'd189, 8'd13,  8'd87,
		8'd223, 8'd245, 8'd36,  8'd169, 8'd62,  8'd168, 8'd67,  8'd201,
		8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34,  8'd185, 8'd3,
		8'd224, 8'd15,  8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
		8'd220, 8'd232, 8'd40,  8'd80,  8'd78,  8'd51,  8'd10,  8'd74,
		8'd167, 8'd151, 8'd96,  8'd115, 8'd30,  8'd0,   8'd98,  8'd68,
		8'd26,  8'd184, 8'd56,  8'd130, 8'd100, 8'd159, 8'd38,  8'd65,
		8'd173, 8'd69,  8'd70,  8'd146, 8'd39,  8'd94,  8'd85,  8'd47,
		8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
		8'd7,   8'd88,  8'd179, 8'd64,  8'd134, 8'd172, 8'd29,  8'd247,
		8'd48,  8'd55,  8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
		8'd225, 8'd27,  8'd131, 8'd73,  8'd76,  8'd63,  8'd248, 8'd254,
		8'd141, 8'd83,  8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
		8'd32,  8'd113, 8'd103, 8'd164, 8'd45,  8'd43,  8'd9,   8'd91,
		8'd203, 8'd155, 8'd37,  8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
		8'd89,  8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
		8'd209, 8'd102, 8'd175, 8'd194, 8'd57,  8'd75,  8'd99,  8'd182
	};

	// coefficients of the linear feedback byte, byte 0 first
	localparam logic [7:0] R_COEF [16] = '{
		8'd1,   8'd148, 8'd32,  8'd133, 8'd16,  8'd194, 8'd192, 8'd1,
		8'd251, 8'd1,   8'd192, 8'd194, 8'd16,  8'd133, 8'd32,  8'd148
	};

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  blk_valid = 1'b0;
	logic  res_ready = 1'b0;
	half_t key_hi    = '0;
	half_t key_lo    = '0;
	half_t data_hi   = '0;
	half_t data_lo   = '0;
	logic  blk_ready;
	logic  res_valid;
	half_t out_hi;
	half_t out_lo;

	block_t expected_rounds [$];
	int     mismatch_count = 0;
	int     stall_cycles   = 0;
	int     hold_request   = 0;
	bit     src_idle_en    = 1'b1;
	bit     sink_idle_en   = 1'b1;

	lsx_block_cipher_round u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.key_hi    (key_hi),
		.key_lo    (key_lo),
		.data_hi   (data_hi),
		.data_lo   (data_lo),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_hi    (out_hi),
		.out_lo    (out_lo)
	);

	// 10 ns clock
	always #5 clk = ~clk;

	// field product with reduction by x^8+x^7+x^6+x+1
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] prod;
		logic [7:0] m;
		prod = 8'h00;
		m    = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				prod = prod ^ m;
			end
			m = m[7] ? ({m[6:0], 1'b0} ^ GF_REDUCE) : {m[6:0], 1'b0};
		end
		return prod;
	endfunction

	// key mix, substitution, then sixteen feedback shifts
	function automatic block_t lsx_round_predict(input block_t round_key, input block_t blk);
		logic [7:0] st [16];
		logic [7:0] fb;
		block_t     x;
		x = round_key ^ blk;
		for (int i = 0; i < 16; i++) begin
			st[i] = PI_SBOX[x[8*i +: 8]];
		end
		for (int r = 0; r < 16; r++) begin
			fb = 8'h00;
			for (int i = 0; i < 16; i++) begin
				fb = fb ^ gf_times(R_COEF[i], st[i]);
			end
			for (int i = 0; i < 15; i++) begin
				st[i] = st[i + 1];
			end
			st[15] = fb;
		end
		for (int i = 0; i < 16; i++) begin
			x[8*i +: 8] = st[i];
		end
		return x;
	endfunction

	function automatic half_t rand_half();
		return {$urandom, $urandom};
	endfunction

	// half block built from bytes that favor all-zero, all-one and one-hot values
	function automatic half_t rand_half_bytes();
		half_t h;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 3))
				0: h[8*i +: 8] = 8'h00;
				1: h[8*i +: 8] = 8'hFF;
				2: h[8*i +: 8] = 8'h01 << $urandom_range(0, 7);
				default: h[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return h;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// offer one block and wait for its transaction
	task automatic send_block(input half_t kh, input half_t kl, input half_t dh, input half_t dl);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			blk_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		blk_valid <= 1'b1;
		key_hi    <= kh;
		key_lo    <= kl;
		data_hi   <= dh;
		data_lo   <= dl;
		do @(posedge clk); while (!blk_ready);
	endtask

	// stop offering and wait until every result is back
	task automatic wait_drain();
		blk_valid <= 1'b0;
		do @(posedge clk); while (expected_rounds.size() != 0);
	endtask

	// corner values of key and data
	task automatic test_directed();
		half_t same_hi;
		half_t same_lo;
		same_hi = rand_half();
		same_lo = rand_half();
		send_block('0, '0, '0, '0);
		send_block('1, '1, '0, '0);
		send_block('0, '0, '1, '1);
		send_block('1, '1, '1, '1);
		send_block(same_hi, same_lo, same_hi, same_lo);
		send_block({32{2'b01}}, {32{2'b10}}, {32{2'b10}}, {32{2'b01}});
		send_block({32{2'b10}}, {32{2'b10}}, '0, '0);
		send_block('0, '0, '1, '0);
		send_block('0, '0, '0, '1);
		send_block(64'h8000_0000_0000_0000, 64'h1, '0, '0);
		for (int i = 0; i < 8; i++) begin
			send_block('0, '0, 64'h80 << (8 * i), 64'h01 << (8 * i));
		end
	endtask

	// random blocks with idling on both sides
	task automatic test_random_idle(input int count);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (count) begin
			send_block(rand_half(), rand_half(), rand_half(), rand_half());
		end
	endtask

	// result side holds off while blocks keep coming, so the pipe fills up
	task automatic test_back_pressure(input int count);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		hold_request = LONG_HOLD;
		repeat (count) begin
			send_block(rand_half(), rand_half(), rand_half(), rand_half());
		end
		wait_drain();
	endtask

	// bursts separated by a full drain
	task automatic test_drain_pause(input int count);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (count) begin
			send_block(rand_half(), rand_half(), rand_half(), rand_half());
		end
		wait_drain();
		repeat (count) begin
			send_block(rand_half(), rand_half(), rand_half(), rand_half());
		end
	endtask

	// byte-structured keys and data
	task automatic test_byte_patterns(input int count);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (count) begin
			send_block(rand_half_bytes(), rand_half_bytes(), rand_half_bytes(),
				rand_half_bytes());
		end
	endtask

	// one block per cycle whenever the round is ready, with no idling
	task automatic test_full_rate(input int count);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (count) begin
			send_block(rand_half(), rand_half(), rand_half(), rand_half());
		end
	endtask

	// result side ready pattern: long hold on request, else random bursts
	initial begin : sink
		int n;
		forever begin
			if (hold_request != 0) begin
				n            = hold_request;
				hold_request = 0;
				res_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// predict on each input transaction, compare each result transaction
	always @(posedge clk) begin : monitor
		block_t want;
		if (arst_n) begin
			if (blk_valid && blk_ready) begin
				expected_rounds.push_back(lsx_round_predict({key_hi, key_lo},
					{data_hi, data_lo}));
			end
			if (res_valid && res_ready) begin
				if (expected_rounds.size() == 0) begin
					report_error($sformatf("unexpected result %h_%h", out_hi, out_lo));
				end else begin
					want = expected_rounds.pop_front();
					if (out_hi !== want[127:64]) begin
						report_error($sformatf("out_hi %h, expected %h", out_hi,
							want[127:64]));
					end
					if (out_lo !== want[63:0]) begin
						report_error($sformatf("out_lo %h, expected %h", out_lo,
							want[63:0]));
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (blk_valid && blk_ready) || (res_valid && res_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_idle(600);
		test_back_pressure(40);
		test_drain_pause(20);
		test_byte_patterns(400);
		test_full_rate(450);

		// let the pipe empty, then wait out the tail before the final check
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rounds.size() != 0) begin
			report_error($sformatf("%0d results never arrived", expected_rounds.size()));
		end
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lsx_pkg.sv
rtl/core/lsx_sub_bytes.sv
rtl/core/lsx_lin_part.sv
rtl/core/lsx_block_cipher_round.sv
tb/sv/lsx_block_cipher_round_tb.sv
